// File: hw/rtl/lipr_pkg.sv
// Shared types, constants and helpers for the linear-interpolation PCM resampler.
package lipr_pkg;

   // Sample and phase widths
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned PHASE_W  = 20;
   localparam int unsigned STEP_W   = 19;
   localparam int unsigned VOL_W    = 7;
   localparam int unsigned GAIN_W   = 22;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 19;

   // One source frame in Q16 phase units
   localparam logic [PHASE_W-1:0] ONE_FRAME = 20'h10000;

   // Results per input transaction are capped at this count
   localparam logic [4:0] MAX_RESULTS = 5'd16;

   // Cycles from operand latch to a finished result in the scaling lanes
   localparam logic [2:0] CALC_LAST = 3'd5;

   // Volume ceiling and the 32767/32768 output trim
   localparam logic [VOL_W-1:0] VOL_MAX = 7'd100;

   // floor(y/100) == (y * RECIP_100) >> RECIP_SHIFT for every y below 2^22
   localparam logic [22:0] RECIP_100   = 23'd5368710;
   localparam int unsigned RECIP_SHIFT = 29;

   // Register indexes on the configuration channel
   localparam logic [CSR_IDX_W-1:0] CSR_SIXTEEN_BIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEREO      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME      = 2'd3;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;     // latch the incoming frame
      logic issue;    // latch operands for one output position, advance phase
      logic loop2;    // hold the current frame (tail of the final frame)
      logic capture;  // take the lane results into the hold register
      logic wrap;     // close the interval: rewind phase, current becomes prior
      logic push;     // move the hold register to the output register
      logic run_end;  // pushed result is the last one of this transaction
      logic clear;    // return to clip start
   } lipr_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic have_prior;
      logic phase_lt_one;
      logic last;
      logic slot_free;
   } lipr_status_type;

   // Normalise a source code to Q15
   function automatic logic [SAMPLE_W-1:0] norm_q15(input logic [SAMPLE_W-1:0] code,
                                                    input logic sixteen);
      norm_q15 = sixteen ? code : {~code[7], code[6:0], 8'h00};
   endfunction

endpackage

// File: hw/rtl/lipr_lane.sv
// Interpolation and gain pipeline for one output channel.
module lipr_lane (
   input  logic               clock,
   input  logic signed [15:0] a,       // start sample, Q15
   input  logic signed [16:0] d,       // end minus start sample
   input  logic        [15:0] f,       // fraction, Q16
   input  logic        [21:0] gain,    // volume * 32767
   output logic signed [15:0] result
);
   import lipr_pkg::*;

   logic signed [33:0] prod_ff;
   logic signed [31:0] v_ff;
   logic               neg_ff;
   logic        [31:0] mag_ff;
   logic        [53:0] scaled_ff;
   logic        [44:0] quot_ff;
   logic        [33:0] v_sum;
   logic        [15:0] q;

   // Q31 interpolated value
   assign v_sum = {{2{a[15]}}, a, 16'h0000} + prod_ff;

   // Free-running stages; operands stay put while a result is worked out
   always_ff @(posedge clock) begin
      prod_ff   <= d * $signed({1'b0, f});
      v_ff      <= v_sum[31:0];
      neg_ff    <= v_ff[31];
      mag_ff    <= v_ff[31] ? (~v_ff + 32'd1) : v_ff;
      scaled_ff <= 54'(mag_ff) * 54'(gain);
      quot_ff   <= 45'(scaled_ff[52:31]) * 45'(RECIP_100);
   end

   // Divide by 100 done; restore sign (truncation toward zero) and saturate
   assign q = quot_ff[44:RECIP_SHIFT];

   always_comb begin
      if (neg_ff) begin
         result = (q > 16'd32768) ? 16'sh8000 : 16'(~q + 16'd1);
      end else begin
         result = (q > 16'd32767) ? 16'sh7FFF : q;
      end
   end

endmodule

// File: hw/rtl/lipr_datapath.sv
// Datapath: configuration registers, frame state, phase, lanes and output register.
module lipr_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [31:0]                req_tdata,
   input  logic                       req_tlast,
   input  logic                       csr_valid,
   input  logic [lipr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lipr_pkg::CSR_DATA_W-1:0] csr_data,
   input  lipr_pkg::lipr_cmd_type     cmd,
   output lipr_pkg::lipr_status_type  status,
   input  logic                       rsp_tready,
   output logic                       rsp_tvalid,
   output logic [31:0]                rsp_tdata,
   output logic                       rsp_tlast
);
   import lipr_pkg::*;

   // Configuration
   logic                sixteen_ff;
   logic                stereo_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [VOL_W-1:0]    vol_ff;
   logic [VOL_W-1:0]    vol_clamped;
   logic [GAIN_W-1:0]   gain_ff;

   // Frame state
   logic [SAMPLE_W-1:0] cur_l_ff, cur_r_ff;
   logic [SAMPLE_W-1:0] prior_l_ff, prior_r_ff;
   logic                last_ff;
   logic                have_prior_ff;
   logic [PHASE_W-1:0]  phase_ff;
   logic [PHASE_W-1:0]  phase_in;
   logic                phase_lt;

   // Operands and results
   logic signed [15:0]  op_a_l_ff, op_a_r_ff;
   logic signed [16:0]  op_d_l_ff, op_d_r_ff;
   logic        [15:0]  op_f_ff;
   logic signed [15:0]  res_l, res_r;
   logic        [15:0]  hold_l_ff, hold_r_ff;
   logic                rsp_valid_ff;
   logic        [31:0]  rsp_data_ff;
   logic                rsp_last_ff;

   logic [SAMPLE_W-1:0] in_l, in_r;

   // Normalise the incoming frame; mono copies left to right
   assign in_l = norm_q15(req_tdata[15:0], sixteen_ff);
   assign in_r = stereo_ff ? norm_q15(req_tdata[31:16], sixteen_ff) : in_l;

   assign phase_lt    = (phase_ff < ONE_FRAME);
   assign vol_clamped = (vol_ff > VOL_MAX) ? VOL_MAX : vol_ff;

   // Phase next value
   always_comb begin
      phase_in = phase_ff;
      if (cmd.clear) begin
         phase_in = '0;
      end else if (cmd.wrap) begin
         phase_in = (have_prior_ff && !phase_lt) ? (phase_ff - ONE_FRAME) : '0;
      end else if (cmd.issue) begin
         phase_in = phase_ff + PHASE_W'(step_ff);
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sixteen_ff <= 1'b1;
         stereo_ff  <= 1'b1;
         step_ff    <= 19'd65536;
         vol_ff     <= VOL_MAX;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SIXTEEN_BIT: sixteen_ff <= csr_data[0];
            CSR_STEREO:      stereo_ff  <= csr_data[0];
            CSR_PHASE_STEP:  step_ff    <= csr_data[STEP_W-1:0];
            CSR_VOLUME:      vol_ff     <= csr_data[VOL_W-1:0];
            default: ;
         endcase
      end
   end

   // Gain: volume * 32767
   always_ff @(posedge clock) begin
      gain_ff <= {vol_clamped, 15'h0000} - GAIN_W'(vol_clamped);
   end

   // Clip state: prior frame, phase, frame held flag
   always_ff @(posedge clock) begin
      if (reset) begin
         prior_l_ff    <= '0;
         prior_r_ff    <= '0;
         have_prior_ff <= 1'b0;
         phase_ff      <= '0;
      end else begin
         phase_ff <= phase_in;
         if (cmd.clear) begin
            prior_l_ff    <= '0;
            prior_r_ff    <= '0;
            have_prior_ff <= 1'b0;
         end else if (cmd.wrap) begin
            prior_l_ff    <= cur_l_ff;
            prior_r_ff    <= cur_r_ff;
            have_prior_ff <= 1'b1;
         end
      end
   end

   // Latch the accepted frame
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_l_ff <= in_l;
         cur_r_ff <= in_r;
         last_ff  <= req_tlast;
      end
   end

   // Latch lane operands for one output position
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         op_f_ff <= phase_ff[15:0];
         if (cmd.loop2) begin
            op_a_l_ff <= cur_l_ff;
            op_a_r_ff <= cur_r_ff;
            op_d_l_ff <= '0;
            op_d_r_ff <= '0;
         end else begin
            op_a_l_ff <= prior_l_ff;
            op_a_r_ff <= prior_r_ff;
            op_d_l_ff <= {cur_l_ff[15], cur_l_ff} - {prior_l_ff[15], prior_l_ff};
            op_d_r_ff <= {cur_r_ff[15], cur_r_ff} - {prior_r_ff[15], prior_r_ff};
         end
      end
   end

   lipr_lane u_lane_l (
      .clock  (clock),
      .a      (op_a_l_ff),
      .d      (op_d_l_ff),
      .f      (op_f_ff),
      .gain   (gain_ff),
      .result (res_l)
   );

   lipr_lane u_lane_r (
      .clock  (clock),
      .a      (op_a_r_ff),
      .d      (op_d_r_ff),
      .f      (op_f_ff),
      .gain   (gain_ff),
      .result (res_r)
   );

   // Hold a finished result until its run_end flag is known
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         hold_l_ff <= res_l;
         hold_r_ff <= res_r;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_data_ff <= {hold_r_ff, hold_l_ff};
         rsp_last_ff <= cmd.run_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign status.have_prior   = have_prior_ff;
   assign status.phase_lt_one = phase_lt;
   assign status.last         = last_ff;
   assign status.slot_free    = !rsp_valid_ff || rsp_tready;

endmodule

// File: hw/rtl/lipr_ctrl.sv
// Controller: sequences output positions, interval wrap and result delivery per frame.
module lipr_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  lipr_pkg::lipr_status_type status,
   output lipr_pkg::lipr_cmd_type    cmd
);
   import lipr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEL,
      ST_PUSH,
      ST_ISSUE,
      ST_CALC,
      ST_WRAP,
      ST_FINISH
   } state_type;

   state_type  state_ff;
   logic [4:0] count_ff;
   logic       loop2_ff;
   logic       hold_ff;
   logic [2:0] calc_ff;
   logic       emit;
   logic       finish_go;

   // Another position lies inside the current interval
   assign emit = status.phase_lt_one && (count_ff < MAX_RESULTS) &&
                 (loop2_ff || status.have_prior);

   assign finish_go = !hold_ff || status.slot_free;

   assign req_tready = (state_ff == ST_IDLE);

   // Commands
   always_comb begin
      cmd.load    = (state_ff == ST_IDLE) && req_tvalid;
      cmd.issue   = (state_ff == ST_ISSUE);
      cmd.loop2   = loop2_ff;
      cmd.capture = (state_ff == ST_CALC) && (calc_ff == CALC_LAST);
      cmd.wrap    = (state_ff == ST_WRAP);
      cmd.push    = ((state_ff == ST_PUSH) && status.slot_free) ||
                    ((state_ff == ST_FINISH) && hold_ff && status.slot_free);
      cmd.run_end = (state_ff == ST_FINISH);
      cmd.clear   = (state_ff == ST_FINISH) && status.last && finish_go;
   end

   // State and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         loop2_ff <= 1'b0;
         hold_ff  <= 1'b0;
         calc_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  count_ff <= '0;
                  loop2_ff <= 1'b0;
                  state_ff <= ST_SEL;
               end
            end
            ST_SEL: begin
               if (emit) begin
                  state_ff <= hold_ff ? ST_PUSH : ST_ISSUE;
               end else if (!loop2_ff) begin
                  state_ff <= ST_WRAP;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_PUSH: begin
               if (status.slot_free) begin
                  hold_ff  <= 1'b0;
                  state_ff <= ST_ISSUE;
               end
            end
            ST_ISSUE: begin
               count_ff <= count_ff + 5'd1;
               calc_ff  <= '0;
               state_ff <= ST_CALC;
            end
            ST_CALC: begin
               if (calc_ff == CALC_LAST) begin
                  hold_ff  <= 1'b1;
                  state_ff <= ST_SEL;
               end else begin
                  calc_ff <= calc_ff + 3'd1;
               end
            end
            ST_WRAP: begin
               if (status.last) begin
                  loop2_ff <= 1'b1;
                  state_ff <= ST_SEL;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (finish_go) begin
                  hold_ff  <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// File: hw/rtl/linear_interp_pcm_resampler.sv
// Linear-interpolation PCM resampler top level.
// One source frame per transaction; frames are taken one at a time.
// Each output frame passes through select, push of the result before it, operand latch and the
// lane calculation; the first of a frame has no push, and a full output register stalls the push.
// Synchronous reset restores register defaults and clip start; no memory needs clearing.
module linear_interp_pcm_resampler (
   input  logic        clock,
   input  logic        reset,
   // Source frames
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] left_code, [31:16] right_code
   input  logic        req_tlast,   // final_frame
   // Output frames
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] left_out, [31:16] right_out
   output logic        rsp_tlast,   // run_end
   // Register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [lipr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lipr_pkg::CSR_DATA_W-1:0] csr_data
);
   import lipr_pkg::*;

   lipr_cmd_type    cmd;
   lipr_status_type status;

   // Register writes never stall
   assign csr_ready = 1'b1;

   lipr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lipr_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // A push never overwrites a result that is still waiting
   a_push_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> status.slot_free)
      else $error("result pushed over a waiting output");

   // Positions are only computed inside the current interval
   a_issue_phase: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> status.phase_lt_one)
      else $error("output issued outside the interval");

   // Interpolation between frames needs a held prior frame
   a_issue_prior: assert property (@(posedge clock) disable iff (reset)
      (cmd.issue && !cmd.loop2) |-> status.have_prior)
      else $error("interpolation issued without a prior frame");

   // End of clip returns to clip start
   a_clear_start: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (!status.have_prior && status.phase_lt_one))
      else $error("state not back at clip start after final frame");

endmodule
